FILE: rtl/core/ahp_pkg.sv
// Shared constants for the modem HTTP reply parser: widths, phase and event
// codes, delimiter bytes and the prefix tables.
// No dependencies.
`default_nettype none

package ahp_pkg;

  localparam int VALUE_BITS  = 16;
  localparam int TOKEN_LIMIT = 80;
  localparam int CNT_W       = 7;
  localparam int PH_W        = 3;
  localparam int EV_W        = 3;
  localparam int NUM_W       = 2;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  // parser phases
  localparam logic [PH_W-1:0] PH_DETECT       = 3'd0;
  localparam logic [PH_W-1:0] PH_ECHO         = 3'd1;
  localparam logic [PH_W-1:0] PH_ACT_METHOD   = 3'd2;
  localparam logic [PH_W-1:0] PH_ACT_STATUS   = 3'd3;
  localparam logic [PH_W-1:0] PH_ACT_LENGTH   = 3'd4;
  localparam logic [PH_W-1:0] PH_READ_LENGTH  = 3'd5;
  localparam logic [PH_W-1:0] PH_READ_CONTENT = 3'd6;

  // result events
  localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
  localparam logic [EV_W-1:0] EV_METHOD      = 3'd1;
  localparam logic [EV_W-1:0] EV_STATUS      = 3'd2;
  localparam logic [EV_W-1:0] EV_READ_REQ    = 3'd3;
  localparam logic [EV_W-1:0] EV_CONTENT_LEN = 3'd4;
  localparam logic [EV_W-1:0] EV_CONTENT     = 3'd5;

  // number scanner phases
  localparam logic [NUM_W-1:0] NUM_SKIP = 2'd0;
  localparam logic [NUM_W-1:0] NUM_IN   = 2'd1;
  localparam logic [NUM_W-1:0] NUM_STOP = 2'd2;
  localparam logic [NUM_W-1:0] NUM_NEG  = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int PFX_AT_LEN   = 3;
  localparam int PFX_ACT_LEN  = 12;
  localparam int PFX_READ_LEN = 10;

  localparam logic [7:0] PFX_AT [PFX_AT_LEN] = '{"A", "T", "+"};
  localparam logic [7:0] PFX_ACT [PFX_ACT_LEN] =
    '{"+", "H", "T", "T", "P", "A", "C", "T", "I", "O", "N", ":"};
  localparam logic [7:0] PFX_READ [PFX_READ_LEN] =
    '{"+", "H", "T", "T", "P", "R", "E", "A", "D", ":"};

endpackage

`default_nettype wire

FILE: rtl/core/ahp_if.sv
// Valid/ready channels of the parser: received bytes in, parse events out.
// Depends on ahp_pkg.
`default_nettype none

interface ahp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ahp_ev_if;
  logic                           valid;
  logic                           ready;
  logic [ahp_pkg::EV_W-1:0]       event_res;
  logic [ahp_pkg::VALUE_BITS-1:0] value;
  logic [7:0]                     data_byte;
  logic                           data_last;

  modport source (output valid, output event_res, output value, output data_byte,
                  output data_last, input ready);
  modport sink (input valid, input event_res, input value, input data_byte,
                input data_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/at_http_response_parser_unit.sv
// An accepted byte is held in the input register; its event beat is then loaded into the
// result register, which drives the event channel.
// Throughput: one byte per cycle while the sink takes beats; a byte waits in the
// input register while a pending beat is not taken, whether or not it causes an event.
// Reset clears the parser to message detection, empty token, no pending beats.
// Depends on ahp_pkg and ahp_if.
`default_nettype none

module at_http_response_parser_unit (
  input  wire  clk_i,
  input  wire  rst_ni,
  ahp_rx_if.sink   rx_i,
  ahp_ev_if.source ev_o
);
  import ahp_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] acc;
    logic [NUM_W-1:0]      nph;
  } num_t;

  function automatic num_t num_feed(input logic [VALUE_BITS-1:0] acc,
                                    input logic [NUM_W-1:0] nph,
                                    input logic [7:0] b);
    num_t                  r;
    logic                  digit;
    logic                  ws;
    logic                  go;
    logic [VALUE_BITS+3:0] wide;
    r.acc = acc;
    r.nph = nph;
    digit = (b >= "0") && (b <= "9");
    ws    = b inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};
    go    = (nph == NUM_IN);
    if (nph == NUM_SKIP) begin
      if (ws) begin
        go = 1'b0;
      end else if (b == CH_PLUS) begin
        r.nph = NUM_IN;
      end else if (b == CH_MINUS) begin
        r.nph = NUM_NEG;
        r.acc = '0;
      end else if (!digit) begin
        r.nph = NUM_STOP;
      end else begin
        r.nph = NUM_IN;
        go    = 1'b1;
      end
    end
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VALUE_BITS{1'b0}}, b[3:0]};
    if (go) begin
      if (digit) begin
        r.acc = (wide[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VALUE_MAX
                                                        : wide[VALUE_BITS-1:0];
      end else begin
        r.nph = NUM_STOP;
      end
    end
    return r;
  endfunction

  // input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // parser state
  logic [PH_W-1:0]       phase_q, phase_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [2:0]            flags_q, flags_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [NUM_W-1:0]      nph_q, nph_d;
  logic [VALUE_BITS-1:0] left_q, left_d;

  // result register
  logic                  out_valid_q;
  logic [EV_W-1:0]       ev_q, ev_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [7:0]            db_q, db_d;
  logic                  last_q, last_d;

  logic                  load;
  logic [7:0]            b;
  logic [2:0]            fl;
  logic                  ovf;
  logic                  restart;
  logic [VALUE_BITS-1:0] num_val;
  num_t                  fed;

  assign load        = s1_valid_q && (!out_valid_q || ev_o.ready);
  assign rx_i.ready  = !s1_valid_q || load;

  always_comb begin
    b       = s1_byte_q;
    fl      = flags_q;
    if (!((cnt_q < CNT_W'(PFX_AT_LEN)) && (PFX_AT[cnt_q[1:0]] == b))) fl[0] = 1'b0;
    if (!((cnt_q < CNT_W'(PFX_ACT_LEN)) && (PFX_ACT[cnt_q[3:0]] == b))) fl[1] = 1'b0;
    if (!((cnt_q < CNT_W'(PFX_READ_LEN)) && (PFX_READ[cnt_q[3:0]] == b))) fl[2] = 1'b0;
    flags_d = fl;
    cnt_d   = cnt_q + 1'b1;
    ovf     = ({1'b0, cnt_q} + 1'b1) >= (CNT_W+1)'(TOKEN_LIMIT);
    restart = ovf;
    if (ovf) begin
      fl = 3'b000;
    end
    // a token restart on overflow also clears the field collected so far
    num_val = ovf ? '0 : acc_q;
    fed     = num_feed(acc_q, nph_q, b);
    acc_d   = acc_q;
    nph_d   = nph_q;
    phase_d = phase_q;
    left_d  = left_q;
    ev_d    = EV_NONE;
    val_d   = '0;
    db_d    = '0;
    last_d  = 1'b0;

    case (phase_q)
      PH_ECHO: begin
        if (b == CH_LF) begin
          phase_d = PH_DETECT;
          restart = 1'b1;
        end
      end
      PH_ACT_METHOD, PH_ACT_STATUS: begin
        if (b == CH_COMMA) begin
          val_d   = num_val;
          restart = 1'b1;
          if (phase_q == PH_ACT_METHOD) begin
            phase_d = PH_ACT_STATUS;
            ev_d    = EV_METHOD;
          end else begin
            phase_d = PH_ACT_LENGTH;
            ev_d    = EV_STATUS;
          end
        end else if (!ovf) begin
          acc_d = fed.acc;
          nph_d = fed.nph;
        end
      end
      PH_ACT_LENGTH, PH_READ_LENGTH: begin
        if (b == CH_LF) begin
          val_d   = num_val;
          restart = 1'b1;
          if (phase_q == PH_ACT_LENGTH) begin
            phase_d = PH_DETECT;
            ev_d    = EV_READ_REQ;
          end else begin
            left_d  = num_val;
            phase_d = PH_READ_CONTENT;
            ev_d    = EV_CONTENT_LEN;
          end
        end else if (!ovf) begin
          acc_d = fed.acc;
          nph_d = fed.nph;
        end
      end
      PH_READ_CONTENT: begin
        ev_d   = EV_CONTENT;
        db_d   = b;
        last_d = (left_q <= VALUE_BITS'(1));
        if (last_d) begin
          left_d  = '0;
          phase_d = PH_DETECT;
          restart = 1'b1;
        end else begin
          left_d = left_q - 1'b1;
        end
      end
      default: begin
        phase_d = PH_DETECT;
        if (b == CH_LF) begin
          restart = 1'b1;
        end else if ((cnt_q == CNT_W'(2)) && fl[0]) begin
          phase_d = PH_ECHO;
        end else if (b == CH_COLON) begin
          if ((cnt_q == CNT_W'(11)) && fl[1]) begin
            phase_d = PH_ACT_METHOD;
          end else if ((cnt_q == CNT_W'(9)) && fl[2]) begin
            phase_d = PH_READ_LENGTH;
          end
          restart = 1'b1;
        end
      end
    endcase

    if (restart) begin
      cnt_d   = '0;
      flags_d = 3'b111;
      acc_d   = '0;
      nph_d   = NUM_SKIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_DETECT;
      cnt_q       <= '0;
      flags_q     <= 3'b111;
      acc_q       <= '0;
      nph_q       <= NUM_SKIP;
      left_q      <= '0;
    end else begin
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      if (load) begin
        out_valid_q <= (ev_d != EV_NONE);
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        flags_q     <= flags_d;
        acc_q       <= acc_d;
        nph_q       <= nph_d;
        left_q      <= left_d;
      end else if (ev_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      s1_byte_q <= rx_i.rx_byte;
    end
    if (load) begin
      ev_q   <= ev_d;
      val_q  <= val_d;
      db_q   <= db_d;
      last_q <= last_d;
    end
  end

  assign ev_o.valid     = out_valid_q;
  assign ev_o.event_res = ev_q;
  assign ev_o.value     = val_q;
  assign ev_o.data_byte = db_q;
  assign ev_o.data_last = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/ahp_checker.sv
// Port-level checks on the parser's event channel, bound to the parser unit.
// Depends on ahp_pkg and at_http_response_parser_unit.
`default_nettype none

module ahp_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             ev_valid_i,
  input wire                             ev_ready_i,
  input wire [ahp_pkg::EV_W-1:0]         event_res_i,
  input wire [ahp_pkg::VALUE_BITS-1:0]   value_i,
  input wire [7:0]                       data_byte_i,
  input wire                             data_last_i
);
  import ahp_pkg::*;

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i && $stable(event_res_i) &&
      $stable(value_i) && $stable(data_byte_i) && $stable(data_last_i))
    else $error("stalled event beat changed");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i |-> (event_res_i != EV_NONE) && (event_res_i <= EV_CONTENT))
    else $error("event beat with no valid event code");

  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i |-> ((event_res_i == EV_CONTENT) && (value_i == '0)) ||
      ((event_res_i != EV_CONTENT) && (data_byte_i == 8'd0) && !data_last_i))
    else $error("unused fields of event beat not zero");

  // nothing can be in flight right after reset
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !ev_valid_i)
    else $error("event beat present right after reset");

endmodule

bind at_http_response_parser_unit ahp_checker u_ahp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .ev_valid_i  (ev_o.valid),
  .ev_ready_i  (ev_o.ready),
  .event_res_i (ev_o.event_res),
  .value_i     (ev_o.value),
  .data_byte_i (ev_o.data_byte),
  .data_last_i (ev_o.data_last)
);

`default_nettype wire

FILE: verif/at_http_response_parser_unit_test.sv
// Self-checking bench for the modem HTTP reply parser: byte stream in, parse events out.
// Uses ahp_pkg and the ahp_rx_if / ahp_ev_if channels; the DUT is at_http_response_parser_unit.
`timescale 1ns / 1ps

module at_http_response_parser_unit_test;
  import ahp_pkg::*;

  localparam int    CYCLE_LIMIT = 500000;
  localparam int    TOTAL_BYTES = 950;
  localparam string CRLF        = "\015\012";

  localparam logic [8*3-1:0]  TXT_AT   = "AT+";
  localparam logic [8*12-1:0] TXT_ACT  = "+HTTPACTION:";
  localparam logic [8*10-1:0] TXT_READ = "+HTTPREAD:";

  typedef struct packed {
    logic [7:0] data;
    bit         wait_idle;
  } rx_item_t;

  typedef struct packed {
    logic [EV_W-1:0]       ev;
    logic [VALUE_BITS-1:0] value;
    logic [7:0]            data;
    logic                  last;
  } ev_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [31:0] cycle_cnt = '0;
  wire         steady = (cycle_cnt[10:9] == 2'b11);

  ahp_rx_if rx_bus ();
  ahp_ev_if ev_bus ();

  at_http_response_parser_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .ev_o   (ev_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser state as predicted
  logic [PH_W-1:0]       exp_phase        = PH_DETECT;
  logic [CNT_W-1:0]      exp_tok_len      = '0;
  logic [2:0]            exp_pfx_live     = 3'b111;
  logic [VALUE_BITS-1:0] exp_number       = '0;
  logic [NUM_W-1:0]      exp_num_mode     = NUM_SKIP;
  logic [VALUE_BITS-1:0] exp_content_left = '0;

  rx_item_t rx_bytes_q[$];
  ev_beat_t pending_events_q[$];
  rx_item_t next_item;
  ev_beat_t got_beat, want_beat;
  bit       idle_next;

  int total_bytes;
  int bytes_accepted;
  int fail_cnt;
  int ev_seen[6];
  int last_seen;
  int send_gap;
  int ready_gap;
  int sink_hold_left;
  bit sink_hold_done;

  // ---------------------------------------------------------------- predictor

  function automatic bit pfx_hit(input logic [95:0] txt, input int len, input int at,
                                 input logic [7:0] b);
    if (at >= len) return 1'b0;
    return txt[8*(len-1-at) +: 8] == b;
  endfunction

  function automatic void restart_token();
    exp_tok_len  = '0;
    exp_pfx_live = 3'b111;
    exp_number   = '0;
    exp_num_mode = NUM_SKIP;
  endfunction

  // atoi-style scan: skip white space, one sign, digits saturate
  function automatic void feed_number(input logic [7:0] b);
    bit          digit;
    int unsigned acc10;
    digit = (b >= "0") && (b <= "9");
    if (exp_num_mode == NUM_SKIP) begin
      if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C) return;
      if (b == CH_PLUS) begin
        exp_num_mode = NUM_IN;
        return;
      end
      if (b == CH_MINUS) begin
        exp_num_mode = NUM_NEG;
        exp_number   = '0;
        return;
      end
      if (!digit) begin
        exp_num_mode = NUM_STOP;
        return;
      end
      exp_num_mode = NUM_IN;
    end
    if (exp_num_mode == NUM_IN) begin
      if (digit) begin
        acc10 = int'(exp_number) * 10 + int'(b - "0");
        exp_number = (acc10 > VALUE_MAX) ? VALUE_MAX : acc10[VALUE_BITS-1:0];
      end else begin
        exp_num_mode = NUM_STOP;
      end
    end
  endfunction

  function automatic void expect_event(input logic [EV_W-1:0] ev,
                                       input logic [VALUE_BITS-1:0] value,
                                       input logic [7:0] data, input logic last);
    ev_beat_t beat;
    beat.ev    = ev;
    beat.value = value;
    beat.data  = data;
    beat.last  = last;
    pending_events_q.push_back(beat);
    ev_seen[ev]++;
    if (last) last_seen++;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int         at;
    logic [2:0] live;
    bit         ovf;
    bit         last;
    at   = exp_tok_len;
    live = exp_pfx_live;
    if (!pfx_hit(TXT_AT, 3, at, b))    live[0] = 1'b0;
    if (!pfx_hit(TXT_ACT, 12, at, b))  live[1] = 1'b0;
    if (!pfx_hit(TXT_READ, 10, at, b)) live[2] = 1'b0;
    exp_pfx_live = live;
    exp_tok_len  = CNT_W'(at + 1);
    ovf = (at + 1) >= TOKEN_LIMIT;
    // overflowing byte is dropped from the token but still seen as delimiter
    if (ovf) begin
      restart_token();
      live = '0;
    end
    case (exp_phase)
      PH_ECHO: begin
        if (b == CH_LF) begin
          exp_phase = PH_DETECT;
          restart_token();
        end
      end
      PH_ACT_METHOD, PH_ACT_STATUS: begin
        if (b == CH_COMMA) begin
          expect_event(exp_phase == PH_ACT_METHOD ? EV_METHOD : EV_STATUS,
                       exp_number, 8'h00, 1'b0);
          exp_phase = (exp_phase == PH_ACT_METHOD) ? PH_ACT_STATUS : PH_ACT_LENGTH;
          restart_token();
        end else if (!ovf) begin
          feed_number(b);
        end
      end
      PH_ACT_LENGTH, PH_READ_LENGTH: begin
        if (b == CH_LF) begin
          if (exp_phase == PH_ACT_LENGTH) begin
            expect_event(EV_READ_REQ, exp_number, 8'h00, 1'b0);
            exp_phase = PH_DETECT;
          end else begin
            expect_event(EV_CONTENT_LEN, exp_number, 8'h00, 1'b0);
            exp_content_left = exp_number;
            exp_phase        = PH_READ_CONTENT;
          end
          restart_token();
        end else if (!ovf) begin
          feed_number(b);
        end
      end
      PH_READ_CONTENT: begin
        // zero or negative length still passes one byte
        last = (exp_content_left <= 1);
        if (last) begin
          exp_content_left = '0;
          exp_phase        = PH_DETECT;
          restart_token();
        end else begin
          exp_content_left = exp_content_left - 1'b1;
        end
        expect_event(EV_CONTENT, '0, b, last);
      end
      default: begin
        exp_phase = PH_DETECT;
        if (b == CH_LF) begin
          restart_token();
        end else if (at == 2 && live[0]) begin
          exp_phase = PH_ECHO;
        end else if (b == CH_COLON) begin
          if (at == 11 && live[1]) exp_phase = PH_ACT_METHOD;
          else if (at == 9 && live[2]) exp_phase = PH_READ_LENGTH;
          restart_token();
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void put_byte(input logic [7:0] b);
    rx_item_t item;
    item.data      = b;
    item.wait_idle = idle_next;
    idle_next      = 1'b0;
    rx_bytes_q.push_back(item);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic string act_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $sformatf("%0d", $urandom_range(0, 999));
    if (r < 70) return $sformatf(" %0d", $urandom_range(0, 65535));
    if (r < 80) return $sformatf("%0d", $urandom_range(65536, 999999));
    if (r < 87) return $sformatf("+%0d", $urandom_range(0, 500));
    if (r < 93) return $sformatf("-%0d", $urandom_range(1, 500));
    if (r < 97) return $sformatf("\011 %0dz", $urandom_range(0, 99));
    return "";
  endfunction

  function automatic void put_read_reply(input int len, input string lead);
    int n;
    put_text({"+HTTPREAD:", lead, $sformatf("%0d", len), CRLF});
    n = (len <= 1) ? 1 : len;
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    put_text({CRLF, "OK", CRLF});
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_bus.valid   <= 1'b0;
      rx_bus.rx_byte <= '0;
      send_gap        = 0;
    end else begin
      if (rx_bus.valid && rx_bus.ready) begin
        parse_byte(rx_bus.rx_byte);
        bytes_accepted++;
      end
      if (rx_bus.valid && !rx_bus.ready) begin
        // hold the beat until taken
      end else if (send_gap > 0) begin
        send_gap--;
        rx_bus.valid <= 1'b0;
      end else if (rx_bytes_q.size() != 0 &&
                   (!rx_bytes_q[0].wait_idle || pending_events_q.size() == 0)) begin
        next_item       = rx_bytes_q.pop_front();
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= next_item.data;
        if (steady) send_gap = 0;
        else begin
          send_gap = $urandom_range(0, 99);
          send_gap = (send_gap < 70) ? 0 :
                     (send_gap < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
      end else begin
        rx_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_bus.ready <= 1'b0;
      ready_gap     = 0;
    end else begin
      if (ev_bus.valid && ev_bus.ready) begin
        got_beat.ev    = ev_bus.event_res;
        got_beat.value = ev_bus.value;
        got_beat.data  = ev_bus.data_byte;
        got_beat.last  = ev_bus.data_last;
        if (pending_events_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: event beat with none expected: ev=%0d value=%0d data=%02h last=%0b",
                     $realtime, got_beat.ev, got_beat.value, got_beat.data, got_beat.last);
        end else begin
          want_beat = pending_events_q.pop_front();
          if (got_beat.ev !== want_beat.ev || got_beat.value !== want_beat.value ||
              got_beat.data !== want_beat.data || got_beat.last !== want_beat.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: event mismatch: expected ev=%0d value=%0d data=%02h last=%0b, %s",
                       $realtime, want_beat.ev, want_beat.value, want_beat.data,
                       want_beat.last,
                       $sformatf("got ev=%0d value=%0d data=%02h last=%0b", got_beat.ev,
                                 got_beat.value, got_beat.data, got_beat.last));
          end
        end
      end
      if (sink_hold_left != 0) begin
        ev_bus.ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        ev_bus.ready <= 1'b0;
      end else if (steady) begin
        ev_bus.ready <= 1'b1;
      end else begin
        ready_gap = $urandom_range(0, 99);
        if (ready_gap < 75) begin
          ready_gap     = 0;
          ev_bus.ready <= 1'b1;
        end else begin
          ready_gap     = (ready_gap < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
          ev_bus.ready <= 1'b0;
        end
      end
    end
  end

  // long sink stall, once, while bytes keep coming so the input backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_hold_left <= 0;
      sink_hold_done <= 1'b0;
    end else if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end else if (!sink_hold_done && bytes_accepted >= 650) begin
      sink_hold_left <= 300;
      sink_hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d bytes taken, %0d events outstanding",
               cycle_cnt, bytes_accepted, total_bytes, pending_events_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int    dir_len;
    int    r;
    int    n;
    int    pos;
    logic [7:0] b;
    string s;

    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    ev_bus.ready   = 1'b0;
    rst_ni         = 1'b0;

    // command echo, plain reply, sign and white space handling, saturation
    put_text({"AT+HTTPACTION=0", CRLF});
    put_text({CRLF, "+HTTPACTION: 0,200,1234", CRLF});
    put_text({"+HTTPACTION:\011+1, -404,99999", CRLF});
    put_text("+HTTPACTION:");
    put_byte(8'h0B);
    put_byte(8'h0C);
    put_byte(8'h0D);
    put_text({" 3,4,5", CRLF});
    put_text({"+HTTPACTION: x,,7a", CRLF});
    put_text({"+HTTPACTION: 65535,65536,", CRLF});
    // content passthrough, zero and negative length, extreme data bytes
    put_text({"+HTTPREAD: 3", CRLF, "abc", CRLF, "OK", CRLF});
    put_text({"+HTTPREAD: 0", CRLF});
    put_byte(CH_LF);
    put_text({"+HTTPREAD:-5", CRLF});
    put_byte(8'hFF);
    put_text({"+HTTPREAD: 2", CRLF});
    put_byte(8'h00);
    put_byte(8'h80);
    // colon that matches no prefix, prefix not at token start
    put_text({"+CSQ: 20,0", CRLF});
    put_text({"+HTTPREAX: 5", CRLF});
    put_text({"x+HTTPREAD: 4", CRLF});
    // token overflow before a prefix and inside a number field
    for (int i = 0; i < 79; i++) put_byte("Z");
    put_text({"+HTTPREAD: 1", CRLF, "k"});
    put_text("+HTTPACTION:");
    for (int i = 0; i < 79; i++) put_byte("9");
    put_text({"42,1,2", CRLF});
    dir_len = rx_bytes_q.size();

    // random traffic, mostly well-formed replies with random content
    idle_next = 1'b1;
    while (rx_bytes_q.size() < TOTAL_BYTES) begin
      if ($urandom_range(0, 99) < 4) idle_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        put_text("AT+HTTP");
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(33, 126)));
        put_text(CRLF);
      end else if (r < 45) begin
        if ($urandom_range(0, 1)) put_text(CRLF);
        put_text({"+HTTPACTION:", act_field(), ",", act_field(), ",", act_field(), CRLF});
      end else if (r < 80) begin
        if ($urandom_range(0, 1)) put_text(CRLF);
        r = $urandom_range(0, 99);
        n = (r < 80) ? $urandom_range(2, 24) :
            (r < 88) ? $urandom_range(0, 1) :
            (r < 94) ? -$urandom_range(1, 99) : $urandom_range(25, 60);
        r = $urandom_range(0, 3);
        put_read_reply(n, r == 0 ? "" : r == 1 ? " " : r == 2 ? "  " : " +");
      end else if (r < 90) begin
        // broken prefix: one character flipped, or cut short
        s   = $urandom_range(0, 1) ? "+HTTPACTION:" : "+HTTPREAD:";
        pos = $urandom_range(0, s.len() - 2);
        if ($urandom_range(0, 1)) begin
          s[pos] = s[pos] ^ 8'h20;
          put_text({s, " 12,34", CRLF});
        end else begin
          put_text({s.substr(0, pos), CRLF});
        end
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(80, 130);
          for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            put_byte(b == CH_LF ? "Q" : b);
          end
        end else begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
        end
        put_text(CRLF);
      end
    end
    total_bytes = rx_bytes_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted != total_bytes || pending_events_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d bytes parsed (%0d directed); events: %0d method, %0d status, %0d read req,",
             total_bytes, dir_len, ev_seen[EV_METHOD], ev_seen[EV_STATUS],
             ev_seen[EV_READ_REQ]);
    $display("%0d content length, %0d content bytes (%0d last); %0d failures",
             ev_seen[EV_CONTENT_LEN], ev_seen[EV_CONTENT], last_seen, fail_cnt);
    if (fail_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ahp_pkg.sv
rtl/core/ahp_if.sv
rtl/core/at_http_response_parser_unit.sv
rtl/core/ahp_checker.sv
verif/at_http_response_parser_unit_test.sv
